// ===== hw/rtl/rrc_pkg.sv =====
package rrc_pkg;

  localparam int MAX_STAGES        = 7;
  localparam int ENTRIES_PER_STAGE = 64;
  localparam int VALUE_BITS        = 48;

  localparam int TABLE_DEPTH = MAX_STAGES * ENTRIES_PER_STAGE;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(ENTRIES_PER_STAGE + 1);
  localparam int KIDX_W      = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
  localparam int SCNT_W      = $clog2(MAX_STAGES + 1);

  localparam int REQ_W   = 2;
  localparam int STAGE_W = 3;
  localparam int CFG_W   = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD      = 2'd0,
    REQ_TRANSLATE = 2'd1,
    REQ_CLEAR     = 2'd2,
    REQ_NOP       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STAGE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] dest;
    logic [VALUE_BITS-1:0] src;
    logic [VALUE_BITS-1:0] len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/rrc_ram.sv =====
module rrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/rrc_match.sv =====
module rrc_match (
  input  logic [rrc_pkg::VALUE_BITS-1:0] value,
  input  rrc_pkg::entry_t                entry,
  output logic                           hit,
  output logic [rrc_pkg::VALUE_BITS-1:0] remapped
);
  import rrc_pkg::*;

  logic [VALUE_BITS:0] diff;

  // value - src with borrow; borrow clear means value >= src
  assign diff     = {1'b0, value} - {1'b0, entry.src};
  assign hit      = !diff[VALUE_BITS] && (diff[VALUE_BITS-1:0] < entry.len);
  assign remapped = diff[VALUE_BITS-1:0] + entry.dest;

endmodule

// ===== hw/rtl/range_remap_cascade.sv =====
// Remap table chain. Load, clear and no-op words skip the stage walk and go to the result.
// A translate word walks the stages in use in order, scanning the entries of each stage
// in table order: the single table RAM port delivers one entry per cycle to
// the shared compare/remap unit, and a stage stops at its first covering entry. One word
// is in flight at a time; in_stall is low only while idle. The result sits in an output
// register, so the next word is accepted while a result still waits on out_stall.
// stages_in_use may be written only while the block is idle.
module range_remap_cascade (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rrc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rrc_pkg::REQ_W-1:0]       in_req_type,
  input  logic [rrc_pkg::STAGE_W-1:0]     in_stage_index,
  input  logic [rrc_pkg::VALUE_BITS-1:0]  in_entry_destination,
  input  logic [rrc_pkg::VALUE_BITS-1:0]  in_entry_source,
  input  logic [rrc_pkg::VALUE_BITS-1:0]  in_entry_length,
  input  logic [rrc_pkg::VALUE_BITS-1:0]  in_query_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rrc_pkg::VALUE_BITS-1:0]  out_mapped_value,
  output logic [rrc_pkg::VALUE_BITS-1:0]  out_running_minimum,
  output logic                            out_minimum_valid,
  output logic                            out_load_rejected
);
  import rrc_pkg::*;

  state_t                state_r, state_nxt;
  req_t                  req_r;
  logic [STAGE_W-1:0]    ld_stage_r;
  entry_t                ld_entry_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [SCNT_W-1:0]     s_r;
  logic [CNT_W-1:0]      k_r;
  logic [CNT_W-1:0]      cnt_r [MAX_STAGES];
  logic [CFG_W-1:0]      cfg_r;
  logic [VALUE_BITS-1:0] min_r;
  logic                  seen_r;

  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_mapped_r;
  logic [VALUE_BITS-1:0] out_min_r;
  logic                  out_seen_r;
  logic                  out_rej_r;

  logic                  in_accept;
  logic                  out_free;
  logic                  done_fire;
  logic [SCNT_W-1:0]     use_w;
  logic [STAGE_W-1:0]    cnt_idx;
  logic [CNT_W-1:0]      cnt_rd;
  logic                  ld_ok;
  logic                  stage_over;
  logic                  scan_last;

  logic                  ram_en;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  entry_t                ram_rdata;

  logic                  hit;
  logic [VALUE_BITS-1:0] remapped;

  logic [VALUE_BITS-1:0] min_nxt;
  logic                  seen_nxt;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign use_w = (int'(cfg_r) > MAX_STAGES) ? SCNT_W'(MAX_STAGES) : SCNT_W'(cfg_r);

  // single count read port, shared by load and the stage walk
  assign cnt_idx = (req_r == REQ_TRANSLATE) ? STAGE_W'(s_r) : ld_stage_r;
  always_comb begin
    cnt_rd = '0;
    for (int i = 0; i < MAX_STAGES; i++) begin
      if (int'(cnt_idx) == i) begin
        cnt_rd = cnt_r[i];
      end
    end
  end

  assign ld_ok      = (int'(ld_stage_r) < MAX_STAGES) && (cnt_rd < CNT_W'(ENTRIES_PER_STAGE));
  assign stage_over = (s_r >= use_w);
  assign scan_last  = (k_r == cnt_rd);

  assign rd_addr = ADDR_W'(s_r) * ADDR_W'(ENTRIES_PER_STAGE) +
                   ((state_r == S_SCAN) ? ADDR_W'(k_r[KIDX_W-1:0]) : '0);
  assign wr_addr = ADDR_W'(ld_stage_r) * ADDR_W'(ENTRIES_PER_STAGE) +
                   ADDR_W'(cnt_rd[KIDX_W-1:0]);

  rrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ld_entry_r),
    .rdata (ram_rdata)
  );

  rrc_match u_match (
    .value    (value_r),
    .entry    (ram_rdata),
    .hit      (hit),
    .remapped (remapped)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (req_t'(in_req_type) == REQ_TRANSLATE) ? S_STAGE : S_DONE;
        end
      end
      S_STAGE: begin
        if (stage_over) begin
          state_nxt = S_DONE;
        end else if (cnt_rd != '0) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || scan_last) begin
          state_nxt = S_STAGE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rd_addr;
    done_fire = 1'b0;
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_STAGE: ram_en = !stage_over && (cnt_rd != '0);
      S_SCAN:  ram_en = !(hit || scan_last);
      S_DONE: begin
        done_fire = out_free;
        if (out_free && req_r == REQ_LOAD && ld_ok) begin
          ram_we   = 1'b1;
          ram_addr = wr_addr;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    min_nxt  = min_r;
    seen_nxt = seen_r;
    unique case (req_r)
      REQ_TRANSLATE: begin
        seen_nxt = 1'b1;
        if (!seen_r || value_r < min_r) begin
          min_nxt = value_r;
        end
      end
      REQ_CLEAR: begin
        min_nxt  = '0;
        seen_nxt = 1'b0;
      end
      REQ_LOAD, REQ_NOP: begin
        min_nxt  = min_r;
        seen_nxt = seen_r;
      end
      default: begin
        min_nxt  = min_r;
        seen_nxt = seen_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_W'(7);
      min_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (done_fire) begin
        min_r       <= min_nxt;
        seen_r      <= seen_nxt;
        for (int i = 0; i < MAX_STAGES; i++) begin
          if (req_r == REQ_CLEAR) begin
            cnt_r[i] <= '0;
          end else if (req_r == REQ_LOAD && ld_ok && int'(ld_stage_r) == i) begin
            cnt_r[i] <= cnt_r[i] + CNT_W'(1);
          end
        end
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r           <= req_t'(in_req_type);
      ld_stage_r      <= in_stage_index;
      ld_entry_r.dest <= in_entry_destination;
      ld_entry_r.src  <= in_entry_source;
      ld_entry_r.len  <= in_entry_length;
      value_r         <= in_query_value;
      s_r             <= '0;
    end
    unique case (state_r)
      S_STAGE: begin
        if (!stage_over) begin
          if (cnt_rd == '0) begin
            s_r <= s_r + SCNT_W'(1);
          end else begin
            k_r <= CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          value_r <= remapped;
          s_r     <= s_r + SCNT_W'(1);
        end else if (scan_last) begin
          s_r <= s_r + SCNT_W'(1);
        end else begin
          k_r <= k_r + CNT_W'(1);
        end
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
    if (done_fire) begin
      out_mapped_r <= (req_r == REQ_TRANSLATE) ? value_r : '0;
      out_min_r    <= min_nxt;
      out_seen_r   <= seen_nxt;
      out_rej_r    <= (req_r == REQ_LOAD) && !ld_ok;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mapped_value    = out_mapped_r;
  assign out_running_minimum = out_min_r;
  assign out_minimum_valid   = out_seen_r;
  assign out_load_rejected   = out_rej_r;

  // scan index always points inside the current stage's filled entries
  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r != '0 && k_r <= cnt_rd))
    else $error("scan index out of range");

  // walk never passes the number of stages in use
  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STAGE || state_r == S_SCAN) |-> (s_r <= use_w))
    else $error("stage counter past stages in use");

  // a translate word starts the stage walk
  a_translate_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && req_t'(in_req_type) == REQ_TRANSLATE) |=> (state_r == S_STAGE))
    else $error("translate word did not start walk");

  // minimum reads zero until a value has been translated
  a_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_seen_r) |-> (out_min_r == '0))
    else $error("minimum nonzero while not valid");

  // table is written only on an accepted load
  a_write_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_DONE && req_r == REQ_LOAD && ld_ok))
    else $error("table write outside load");

endmodule

// ===== test/tb_range_remap_cascade.sv =====
module tb_range_remap_cascade;
  import rrc_pkg::*;

  typedef logic [VALUE_BITS-1:0] value_t;

  localparam value_t VMAX         = '1;
  localparam int     STALL_LIMIT  = 4000;
  localparam int     RANDOM_ITEMS = 1330;

  typedef struct {
    value_t mapped;
    value_t minimum;
    logic   min_ok;
    logic   rejected;
  } remap_result_t;

  class remap_scoreboard;
    value_t        dest_tab [MAX_STAGES][ENTRIES_PER_STAGE];
    value_t        src_tab  [MAX_STAGES][ENTRIES_PER_STAGE];
    value_t        len_tab  [MAX_STAGES][ENTRIES_PER_STAGE];
    int unsigned   fill     [MAX_STAGES];
    value_t        low_mark;
    logic          low_seen;
    int unsigned   stages_on;
    remap_result_t awaited [$];
    int            errors;
    int            n_translate;
    int            n_rejected;
    int            n_checked;

    function new();
      foreach (fill[i]) fill[i] = 0;
      low_mark    = '0;
      low_seen    = 1'b0;
      stages_on   = MAX_STAGES;
      errors      = 0;
      n_translate = 0;
      n_rejected  = 0;
      n_checked   = 0;
    endfunction

    // first covering entry of each stage wins; uncovered values pass the stage
    function value_t remap_chain(value_t v);
      int unsigned depth;
      depth = (stages_on > MAX_STAGES) ? MAX_STAGES : stages_on;
      for (int s = 0; s < depth; s++) begin
        for (int k = 0; k < fill[s]; k++) begin
          if (v >= src_tab[s][k] && v - src_tab[s][k] < len_tab[s][k]) begin
            v = v + dest_tab[s][k] - src_tab[s][k];
            break;
          end
        end
      end
      return v;
    endfunction

    function void note_word(req_t req, logic [STAGE_W-1:0] stage,
                            value_t d, value_t s, value_t l, value_t q);
      remap_result_t r;
      r.mapped   = '0;
      r.rejected = 1'b0;
      case (req)
        REQ_LOAD: begin
          if (stage >= MAX_STAGES || fill[stage] >= ENTRIES_PER_STAGE) begin
            r.rejected = 1'b1;
            n_rejected++;
          end else begin
            dest_tab[stage][fill[stage]] = d;
            src_tab[stage][fill[stage]]  = s;
            len_tab[stage][fill[stage]]  = l;
            fill[stage]++;
          end
        end
        REQ_TRANSLATE: begin
          r.mapped = remap_chain(q);
          if (!low_seen || r.mapped < low_mark) low_mark = r.mapped;
          low_seen = 1'b1;
          n_translate++;
        end
        REQ_CLEAR: begin
          foreach (fill[i]) fill[i] = 0;
          low_mark = '0;
          low_seen = 1'b0;
        end
        default: ;
      endcase
      r.minimum = low_mark;
      r.min_ok  = low_seen;
      awaited.insert(awaited.size(), r);
    endfunction

    function void compare_field(string what, value_t want, value_t got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_word(value_t mapped, value_t minimum, logic min_ok, logic rejected);
      remap_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result word with nothing outstanding, expected none, actual %h",
                 $time, mapped);
        errors++;
        return;
      end
      e = awaited.pop_front();
      n_checked++;
      compare_field("mapped_value", e.mapped, mapped);
      compare_field("running_minimum", e.minimum, minimum);
      compare_field("minimum_valid", value_t'(e.min_ok), value_t'(min_ok));
      compare_field("load_rejected", value_t'(e.rejected), value_t'(rejected));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     in_req_type;
  logic [STAGE_W-1:0]   in_stage_index;
  value_t               in_entry_destination;
  value_t               in_entry_source;
  value_t               in_entry_length;
  value_t               in_query_value;
  logic                 out_valid;
  logic                 out_stall;
  value_t               out_mapped_value;
  value_t               out_running_minimum;
  logic                 out_minimum_valid;
  logic                 out_load_rejected;

  remap_scoreboard sb = new();

  int burst_left = 0;
  int quiet      = 0;
  int stim_count = 0;
  int n_settings = 0;
  int stall_mode = 0;
  int stall_cyc  = 0;

  range_remap_cascade u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: switches between no stall, light, heavy and periodic stalling
  always @(negedge clk) begin
    stall_cyc++;
    if (stall_cyc % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall = 1'b0;
      1:       out_stall = ($urandom_range(0, 3) == 0);
      2:       out_stall = ($urandom_range(0, 3) != 0);
      default: out_stall = ((stall_cyc % 13) < 9);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_word(req_t'(in_req_type), in_stage_index, in_entry_destination,
                     in_entry_source, in_entry_length, in_query_value);
      if (out_valid && !out_stall)
        sb.check_word(out_mapped_value, out_running_minimum, out_minimum_valid,
                      out_load_rejected);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                   $time, quiet, sb.awaited.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  function automatic value_t rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VALUE_BITS-1:0];
  endfunction

  // 0: narrow range so stages chain, 1: full width, else corner values or full width
  function automatic value_t pick_value(int mode, bit is_len);
    case (mode)
      0: return is_len ? value_t'($urandom_range(0, 300)) : value_t'($urandom_range(0, 4095));
      1: return rand48();
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return value_t'(1);
          2:       return VMAX;
          3:       return VMAX - 1;
          default: return rand48();
        endcase
      end
    endcase
  endfunction

  // value inside (or just past) an entry already loaded into stage s
  function automatic value_t covered_value(int unsigned s, int mode);
    int unsigned k;
    value_t      base;
    value_t      span;
    if (sb.fill[s] == 0) return pick_value(mode, 1'b0);
    k    = $urandom_range(0, sb.fill[s] - 1);
    base = sb.src_tab[s][k];
    span = sb.len_tab[s][k];
    if (span == 0) return base;
    case ($urandom_range(0, 3))
      0:       return base + span - 1;
      1:       return base + span;
      default: return base + rand48() % span;
    endcase
  endfunction

  task automatic send_word(req_t req, logic [STAGE_W-1:0] stage,
                           value_t d, value_t s, value_t l, value_t q);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid             = 1'b1;
    in_req_type          = req;
    in_stage_index       = stage;
    in_entry_destination = d;
    in_entry_source      = s;
    in_entry_length      = l;
    in_query_value       = q;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_entry(logic [STAGE_W-1:0] stage, value_t d, value_t s, value_t l);
    send_word(REQ_LOAD, stage, d, s, l, rand48());
  endtask

  task automatic translate(value_t q);
    send_word(REQ_TRANSLATE, STAGE_W'($urandom_range(0, 7)), rand48(), rand48(), rand48(), q);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_stages(logic [CFG_W-1:0] v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we       = 1'b0;
    sb.stages_on = 32'(v);
    n_settings++;
  endtask

  initial begin
    int phase;
    int mode;
    int pick;
    int body;
    int st;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_valid             = 1'b0;
    in_req_type          = REQ_NOP;
    in_stage_index       = '0;
    in_entry_destination = '0;
    in_entry_source      = '0;
    in_entry_length      = '0;
    in_query_value       = '0;
    out_stall            = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty tables at the reset stage count
    translate('0);
    translate(VMAX);
    send_word(REQ_NOP, 3'd2, rand48(), rand48(), rand48(), rand48());
    load_entry(3'd7, 'h1, 'h2, 'h3);          // stage index past the last stage
    load_entry(3'd0, 'h100, 'h10, 'h10);
    load_entry(3'd0, 'h0, 'h0, '0);           // zero length covers nothing
    load_entry(3'd0, 'h5000, 'h18, 'h8);      // overlaps, earlier entry wins
    translate('h1f);                          // last covered value
    translate('h20);                          // one past the interval
    translate('h10);
    load_entry(3'd1, '0, 'h100, 'h1);
    load_entry(3'd6, VMAX, VMAX - 'hf, VMAX); // interval runs past the top
    translate('h10);
    translate(VMAX);
    load_entry(3'd2, 'h1, '0, VMAX);
    load_entry(3'd5, VMAX, VMAX, VMAX);
    translate('h7);
    translate(VMAX);
    write_stages(3'd0);                       // no stage applied
    translate('h10);
    write_stages(3'd1);
    translate('h1f);
    send_word(REQ_CLEAR, 3'd0, rand48(), rand48(), rand48(), rand48());
    translate('h5);
    load_entry(3'd4, '0, '0, '0);

    phase = 0;
    while (stim_count < RANDOM_ITEMS) begin
      if (phase == 0)      write_stages(3'd7);
      else if (phase == 1) write_stages(3'd0);
      else                 write_stages(CFG_W'($urandom_range(0, 7)));
      pick = $urandom_range(0, 9);
      mode = (pick < 6) ? 0 : ((pick < 8) ? 1 : 2);

      if (phase % 6 == 3) begin
        // push one stage to its limit, then a few more loads that must be refused
        st = $urandom_range(0, MAX_STAGES - 1);
        repeat (ENTRIES_PER_STAGE - sb.fill[st] + 3) begin
          load_entry(STAGE_W'(st), pick_value(mode, 1'b0), pick_value(mode, 1'b0),
                     pick_value(mode, 1'b1));
          stim_count++;
        end
        repeat (15) begin
          translate(covered_value(($urandom_range(0, 2) == 0) ? st : 0, mode));
          stim_count++;
        end
      end else begin
        if ($urandom_range(0, 9) < 4) begin
          send_word(REQ_CLEAR, STAGE_W'($urandom_range(0, 7)), rand48(), rand48(), rand48(),
                    rand48());
          stim_count++;
        end
        body = $urandom_range(40, 110);
        repeat (body) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) begin
            send_word(REQ_NOP, STAGE_W'($urandom_range(0, 7)), rand48(), rand48(), rand48(),
                      rand48());
            stim_count++;
          end else if (pick < 7) begin
            load_entry(3'd7, rand48(), rand48(), rand48());
            stim_count++;
          end else if (pick < 9) begin
            send_word(REQ_CLEAR, STAGE_W'($urandom_range(0, 7)), rand48(), rand48(), rand48(),
                      rand48());
            stim_count++;
          end else if (pick < 10) begin
            drain();
          end else if (pick < 45) begin
            load_entry(STAGE_W'($urandom_range(0, MAX_STAGES - 1)), pick_value(mode, 1'b0),
                       pick_value(mode, 1'b0), pick_value(mode, 1'b1));
            stim_count++;
          end else begin
            if ($urandom_range(0, 9) < 7)
              translate(covered_value(($urandom_range(0, 3) == 0) ?
                                      $urandom_range(0, MAX_STAGES - 1) : 0, mode));
            else
              translate(pick_value(mode, 1'b0));
            stim_count++;
          end
        end
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);

    $display("ran %0d result words: %0d translations, %0d refused loads",
             sb.n_checked, sb.n_translate, sb.n_rejected);
    $display("stage count written %0d times over %0d random phases, %0d mismatches",
             n_settings, phase, sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
